// ===== hdl/wgts_pkg.sv =====
// Shared types and constants for the widest-gap target selector.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package wgts_pkg;

   // Field widths
   localparam int unsigned RANGE_W = 20;
   localparam int unsigned IDX_W   = 11;
   localparam int unsigned LEN_W   = 12;
   localparam int unsigned TOL_W   = 16;

   // Configuration port
   localparam int unsigned CSR_ADDR_W = 1;
   localparam int unsigned CSR_DATA_W = 16;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_CENTER_INDEX  = 1'b0,
      CSR_TIE_TOLERANCE = 1'b1
   } csr_addr_type;

   localparam logic [IDX_W-1:0] CENTER_INDEX_RESET  = 11'd1024;
   localparam logic [TOL_W-1:0] TIE_TOLERANCE_RESET = 16'd33;

   // One beam word
   typedef struct packed {
      logic [RANGE_W-1:0] range_value;
      logic               last_beam;
   } beam_type;

   // One result word
   typedef struct packed {
      logic [IDX_W-1:0] target_index;
      logic [LEN_W-1:0] gap_length;
   } result_type;

endpackage : wgts_pkg

`default_nettype wire

// ===== hdl/wgts_in_stage.sv =====
// Input register for beam words of the widest-gap target selector.
// Depends on wgts_pkg for the beam word type.
`default_nettype none

module wgts_in_stage
   import wgts_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire beam_type req_beam,
   output logic          beam_valid,
   output beam_type      beam,
   input  wire logic     beam_take
);

   logic     valid_ff;
   logic     valid_in;
   beam_type beam_ff;

   // Accept a new word whenever the held one leaves or the stage is empty
   assign req_ready = !valid_ff || beam_take;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the payload until the word is taken
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         beam_ff <= req_beam;
      end
   end

   assign beam_valid = valid_ff;
   assign beam       = beam_ff;

endmodule : wgts_in_stage

`default_nettype wire

// ===== hdl/wgts_gap_track.sv =====
// Running gap tracker: current run, its pick, and the widest run so far.
// Depends on wgts_pkg for widths and the beam and result word types.
`default_nettype none

module wgts_gap_track
   import wgts_pkg::*;
#(
   parameter int unsigned SCAN_BEAMS_MAX = 2048
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             beam_valid,
   input  wire beam_type         beam,
   output logic                  beam_take,
   input  wire logic             out_free,
   input  wire logic [IDX_W-1:0] center_index,
   input  wire logic [TOL_W-1:0] tie_tolerance,
   output logic                  res_load,
   output result_type            res
);

   localparam int unsigned CNT_W   = $clog2(SCAN_BEAMS_MAX);
   localparam int unsigned LEN_TOP = (1 << LEN_W) - 1;
   localparam int unsigned CAP_INT = (SCAN_BEAMS_MAX > LEN_TOP) ? LEN_TOP : SCAN_BEAMS_MAX;
   localparam logic [LEN_W-1:0]   LEN_CAP  = LEN_W'(CAP_INT);
   localparam logic [CNT_W:0]     CNT_WRAP = (CNT_W+1)'(SCAN_BEAMS_MAX);

   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [LEN_W-1:0]   run_len_ff, run_len_in;
   logic [RANGE_W-1:0] run_max_ff, run_max_in;
   logic [IDX_W-1:0]   run_pick_ff, run_pick_in;
   logic [LEN_W-1:0]   best_len_ff, best_len_in;
   logic [IDX_W-1:0]   best_pick_ff, best_pick_in;

   logic [CNT_W:0]     cnt_inc;
   logic [IDX_W-1:0]   idx;
   logic [RANGE_W-1:0] max_gap;
   logic [LEN_W-1:0]   run_len_n;
   logic [RANGE_W-1:0] run_max_n;
   logic [IDX_W-1:0]   run_pick_n;
   logic [LEN_W-1:0]   best_len_c;
   logic [IDX_W-1:0]   best_pick_c;

   function automatic logic [IDX_W-1:0] center_dist(
      input logic [IDX_W-1:0] a,
      input logic [IDX_W-1:0] c
   );
      return (a >= c) ? (a - c) : (c - a);
   endfunction

   // A last beam waits while the result register is still full
   assign beam_take = beam_valid && (!beam.last_beam || out_free);
   assign res_load  = beam_take && beam.last_beam;

   assign idx     = IDX_W'(cnt_ff);
   assign cnt_inc = {1'b0, cnt_ff} + (CNT_W+1)'(1);
   assign max_gap = run_max_ff - beam.range_value;

   // Update the current run, closing it on a blocked beam
   always_comb begin
      run_len_n   = run_len_ff;
      run_max_n   = run_max_ff;
      run_pick_n  = run_pick_ff;
      best_len_c  = best_len_ff;
      best_pick_c = best_pick_ff;
      if (beam.range_value == '0) begin
         if (run_len_ff > best_len_ff) begin
            best_len_c  = run_len_ff;
            best_pick_c = run_pick_ff;
         end
         run_len_n  = '0;
         run_max_n  = '0;
         run_pick_n = '0;
      end else begin
         if (run_len_ff == '0 || beam.range_value > run_max_ff) begin
            run_max_n  = beam.range_value;
            run_pick_n = idx;
         end else if (max_gap < RANGE_W'(tie_tolerance)) begin
            // Near-tie: prefer the beam closer to straight ahead
            if (center_dist(idx, center_index) < center_dist(run_pick_ff, center_index)) begin
               run_pick_n = idx;
            end
         end
         if (run_len_ff < LEN_CAP) begin
            run_len_n = run_len_ff + LEN_W'(1);
         end
      end
   end

   // Close the run once more at scan end to form the result
   always_comb begin
      if (run_len_n > best_len_c) begin
         res.target_index = run_pick_n;
         res.gap_length   = run_len_n;
      end else begin
         res.target_index = best_pick_c;
         res.gap_length   = best_len_c;
      end
   end

   // Advance the beam counter, clear the scan after a last beam
   always_comb begin
      cnt_in       = cnt_ff;
      run_len_in   = run_len_ff;
      run_max_in   = run_max_ff;
      run_pick_in  = run_pick_ff;
      best_len_in  = best_len_ff;
      best_pick_in = best_pick_ff;
      if (beam_take) begin
         if (beam.last_beam) begin
            cnt_in       = '0;
            run_len_in   = '0;
            run_max_in   = '0;
            run_pick_in  = '0;
            best_len_in  = '0;
            best_pick_in = '0;
         end else begin
            cnt_in       = (cnt_inc >= CNT_WRAP) ? '0 : cnt_inc[CNT_W-1:0];
            run_len_in   = run_len_n;
            run_max_in   = run_max_n;
            run_pick_in  = run_pick_n;
            best_len_in  = best_len_c;
            best_pick_in = best_pick_c;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         run_len_ff   <= '0;
         run_max_ff   <= '0;
         run_pick_ff  <= '0;
         best_len_ff  <= '0;
         best_pick_ff <= '0;
      end else begin
         cnt_ff       <= cnt_in;
         run_len_ff   <= run_len_in;
         run_max_ff   <= run_max_in;
         run_pick_ff  <= run_pick_in;
         best_len_ff  <= best_len_in;
         best_pick_ff <= best_pick_in;
      end
   end

endmodule : wgts_gap_track

`default_nettype wire

// ===== hdl/wgts_out_stage.sv =====
// Result register of the widest-gap target selector.
// Depends on wgts_pkg for the result word type.
`default_nettype none

module wgts_out_stage
   import wgts_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       res_load,
   input  wire result_type res,
   output logic            out_free,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output result_type      rsp_result
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   // The slot frees when empty or when the receiver takes the word
   assign out_free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (rsp_ready) begin
         valid_in = 1'b0;
      end
      if (res_load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         result_ff <= res;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule : wgts_out_stage

`default_nettype wire

// ===== hdl/widest_gap_target_select.sv =====
// Widest-gap target selector, top level.
// Beam words arrive on req_ (range_value, last_beam) with valid/ready. Beams
// are indexed from 0 in arrival order; a zero range is a blocked beam. The
// block tracks the longest run of nonzero beams (first run wins a tie) and
// the beam of greatest range inside it, moving to a near-equal beam closer
// to center_index. On the last beam of a scan one result word goes out on
// rsp_ (target_index, gap_length) and the scan state clears.
// Throughput: one beam per cycle, set by the input register feeding the
// tracker compares, while no last beam waits on a full result register.
// A last beam's result is loaded into the result register and shown there.
// csr_ writes (index 0 center_index, 1 tie_tolerance) are registered first.
// Reset: empties both registers, clears the scan state, and sets
// center_index to 1024 and tie_tolerance to 33.
// Receiver stall: the result word holds; non-last beams keep flowing, and a
// last beam waits in the input register, dropping req_ready, until the
// pending result is taken. Depends on wgts_pkg and the wgts_ submodules.
`default_nettype none

module widest_gap_target_select
   import wgts_pkg::*;
#(
   parameter int unsigned SCAN_BEAMS_MAX = 2048
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [RANGE_W-1:0]    req_range_value,
   input  wire logic                  req_last_beam,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [IDX_W-1:0]           rsp_target_index,
   output logic [LEN_W-1:0]           rsp_gap_length,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_ADDR_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int unsigned LEN_TOP = (1 << LEN_W) - 1;
   localparam int unsigned CAP_INT = (SCAN_BEAMS_MAX > LEN_TOP) ? LEN_TOP : SCAN_BEAMS_MAX;
   localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(CAP_INT);

   logic [IDX_W-1:0] center_ff, center_in;
   logic [TOL_W-1:0] tol_ff, tol_in;

   beam_type   req_beam;
   beam_type   beam;
   logic       beam_valid;
   logic       beam_take;
   logic       out_free;
   logic       res_load;
   result_type res;
   result_type rsp_result;

   // Decode configuration writes
   always_comb begin
      center_in = center_ff;
      tol_in    = tol_ff;
      if (csr_write_enable) begin
         unique case (csr_addr_type'(csr_index))
            CSR_CENTER_INDEX:  center_in = csr_write_data[IDX_W-1:0];
            CSR_TIE_TOLERANCE: tol_in    = csr_write_data[TOL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= CENTER_INDEX_RESET;
         tol_ff    <= TIE_TOLERANCE_RESET;
      end else begin
         center_ff <= center_in;
         tol_ff    <= tol_in;
      end
   end

   assign req_beam.range_value = req_range_value;
   assign req_beam.last_beam   = req_last_beam;

   wgts_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_beam   (req_beam),
      .beam_valid (beam_valid),
      .beam       (beam),
      .beam_take  (beam_take)
   );

   wgts_gap_track #(
      .SCAN_BEAMS_MAX (SCAN_BEAMS_MAX)
   ) u_gap_track (
      .clock         (clock),
      .reset         (reset),
      .beam_valid    (beam_valid),
      .beam          (beam),
      .beam_take     (beam_take),
      .out_free      (out_free),
      .center_index  (center_ff),
      .tie_tolerance (tol_ff),
      .res_load      (res_load),
      .res           (res)
   );

   wgts_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .res_load   (res_load),
      .res        (res),
      .out_free   (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result)
   );

   assign rsp_target_index = rsp_result.target_index;
   assign rsp_gap_length   = rsp_result.gap_length;

   // A gap never exceeds the run length cap
   a_len_capped : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_gap_length <= LEN_CAP)
      else $error("gap length above cap");

   // An empty scan reports index zero
   a_empty_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_gap_length == '0) |-> rsp_target_index == '0)
      else $error("nonzero index for empty scan");

   // A taken last beam always produces a result word next cycle
   a_last_emits : assert property (@(posedge clock) disable iff (reset)
      res_load |=> rsp_valid)
      else $error("last beam lost its result");

   // The input stage only stalls while it holds a word
   a_ready_empty : assert property (@(posedge clock) disable iff (reset)
      !beam_valid |-> req_ready)
      else $error("input stalled while empty");

endmodule : widest_gap_target_select

`default_nettype wire
